// ----- hw/rtl/tlqe_pkg.sv -----
// tlqe_pkg: shared widths, types and helper function of the thick line quad expander
`default_nettype none
package tlqe_pkg;

  localparam int CoordBits  = 16;
  localparam int WidthBits  = 12;
  localparam int ColorBits  = 32;
  localparam int DiffW      = CoordBits + 1;
  localparam int SqW        = 2 * DiffW;
  localparam int FracShift  = 16;
  localparam int RadW       = SqW + FracShift;
  localparam int LenW       = (RadW + 1) / 2;
  localparam int ScaleShift = 7;
  localparam int ProdW      = DiffW + WidthBits;
  localparam int NumW       = ProdW + ScaleShift;
  localparam int QW         = WidthBits - 1;
  localparam int HW         = QW + 1;
  localparam int SumW       = ((CoordBits > HW) ? CoordBits : HW) + 1;
  localparam int NumVerts   = 6;
  localparam int CntW       = 3;
  localparam logic [CntW-1:0] LastIdx = CntW'(NumVerts - 1);

  typedef struct packed {
    logic signed [CoordBits-1:0] x1;
    logic signed [CoordBits-1:0] y1;
    logic signed [CoordBits-1:0] x2;
    logic signed [CoordBits-1:0] y2;
    logic [ColorBits-1:0]        rgba;
  } seg_t;

  typedef struct packed {
    seg_t            seg;
    logic            negx;
    logic            negy;
    logic            zero;
    logic [NumW-1:0] numx;
    logic [NumW-1:0] numy;
  } carry_t;

  function automatic logic [CoordBits-1:0] sat_coord(input logic [SumW-1:0] v);
    logic [SumW-CoordBits:0] top;
    logic [CoordBits-1:0]    res;
    top = v[SumW-1:CoordBits-1];
    if ((top == '0) || (top == '1)) begin
      res = v[CoordBits-1:0];
    end else if (v[SumW-1]) begin
      res = {1'b1, {(CoordBits-1){1'b0}}};
    end else begin
      res = {1'b0, {(CoordBits-1){1'b1}}};
    end
    return res;
  endfunction

endpackage
`default_nettype wire

// ----- hw/rtl/tlqe_front.sv -----
// tlqe_front: differences, squares, offset numerators and squared length
`default_nettype none
module tlqe_front (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          adv_i,
  input  wire logic                          vld_i,
  input  wire tlqe_pkg::seg_t                seg_i,
  input  wire logic [tlqe_pkg::WidthBits-1:0] width_i,
  output logic                               vld_o,
  output logic [tlqe_pkg::RadW-1:0]          rad_o,
  output tlqe_pkg::carry_t                   car_o
);

  logic                                  v1_q, v2_q, v3_q;
  tlqe_pkg::seg_t                        seg1_q, seg2_q;
  logic [tlqe_pkg::WidthBits-1:0]        t1_q;
  logic signed [tlqe_pkg::DiffW-1:0]     dx1_q, dy1_q;
  logic [tlqe_pkg::DiffW-1:0]            mdx_d, mdy_d;
  logic [tlqe_pkg::SqW-1:0]              sqx2_q, sqy2_q;
  logic [tlqe_pkg::ProdW-1:0]            prx2_q, pry2_q;
  logic                                  negx2_q, negy2_q;
  logic [tlqe_pkg::SqW-1:0]              sq_d;
  logic [tlqe_pkg::RadW-1:0]             rad3_q;
  tlqe_pkg::carry_t                      car3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else if (adv_i) begin
      v1_q <= vld_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  assign mdx_d = dx1_q[tlqe_pkg::DiffW-1] ? tlqe_pkg::DiffW'(-dx1_q) : tlqe_pkg::DiffW'(dx1_q);
  assign mdy_d = dy1_q[tlqe_pkg::DiffW-1] ? tlqe_pkg::DiffW'(-dy1_q) : tlqe_pkg::DiffW'(dy1_q);
  assign sq_d  = sqx2_q + sqy2_q;

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      seg1_q  <= seg_i;
      t1_q    <= width_i;
      dx1_q   <= {seg_i.x2[tlqe_pkg::CoordBits-1], seg_i.x2}
               - {seg_i.x1[tlqe_pkg::CoordBits-1], seg_i.x1};
      dy1_q   <= {seg_i.y2[tlqe_pkg::CoordBits-1], seg_i.y2}
               - {seg_i.y1[tlqe_pkg::CoordBits-1], seg_i.y1};
      seg2_q  <= seg1_q;
      sqx2_q  <= tlqe_pkg::SqW'(mdx_d) * tlqe_pkg::SqW'(mdx_d);
      sqy2_q  <= tlqe_pkg::SqW'(mdy_d) * tlqe_pkg::SqW'(mdy_d);
      prx2_q  <= tlqe_pkg::ProdW'(mdy_d) * tlqe_pkg::ProdW'(t1_q);
      pry2_q  <= tlqe_pkg::ProdW'(mdx_d) * tlqe_pkg::ProdW'(t1_q);
      negx2_q <= !dy1_q[tlqe_pkg::DiffW-1] && (dy1_q != '0);
      negy2_q <= dx1_q[tlqe_pkg::DiffW-1];
      rad3_q      <= {sq_d, {tlqe_pkg::FracShift{1'b0}}};
      car3_q.seg  <= seg2_q;
      car3_q.negx <= negx2_q;
      car3_q.negy <= negy2_q;
      car3_q.zero <= (sq_d == '0);
      car3_q.numx <= {prx2_q, {tlqe_pkg::ScaleShift{1'b0}}};
      car3_q.numy <= {pry2_q, {tlqe_pkg::ScaleShift{1'b0}}};
    end
  end

  assign vld_o = v3_q;
  assign rad_o = rad3_q;
  assign car_o = car3_q;

endmodule
`default_nettype wire

// ----- hw/rtl/tlqe_sqrt.sv -----
// tlqe_sqrt: pipelined floor square root, one root bit per stage
`default_nettype none
module tlqe_sqrt (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire logic                      vld_i,
  input  wire logic [tlqe_pkg::RadW-1:0] rad_i,
  input  wire tlqe_pkg::carry_t          car_i,
  output logic                           vld_o,
  output logic [tlqe_pkg::LenW-1:0]      len_o,
  output tlqe_pkg::carry_t               car_o
);

  logic                          vld_w  [tlqe_pkg::LenW+1];
  logic [tlqe_pkg::RadW-1:0]     rem_w  [tlqe_pkg::LenW+1];
  logic [tlqe_pkg::LenW-1:0]     root_w [tlqe_pkg::LenW+1];
  tlqe_pkg::carry_t              car_w  [tlqe_pkg::LenW+1];

  assign vld_w[0]  = vld_i;
  assign rem_w[0]  = rad_i;
  assign root_w[0] = '0;
  assign car_w[0]  = car_i;

  for (genvar k = 0; k < tlqe_pkg::LenW; k++) begin : g_stage
    localparam int Bit = tlqe_pkg::LenW - 1 - k;
    logic [tlqe_pkg::RadW:0] trial_d;
    logic                    ge_d;

    assign trial_d = ((tlqe_pkg::RadW+1)'(root_w[k]) << (Bit + 1))
                   | ((tlqe_pkg::RadW+1)'(1) << (2 * Bit));
    assign ge_d    = {1'b0, rem_w[k]} >= trial_d;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_w[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_w[k+1] <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        rem_w[k+1]  <= ge_d ? rem_w[k] - trial_d[tlqe_pkg::RadW-1:0] : rem_w[k];
        root_w[k+1] <= ge_d ? (root_w[k] | (tlqe_pkg::LenW'(1) << Bit)) : root_w[k];
        car_w[k+1]  <= car_w[k];
      end
    end
  end

  assign vld_o = vld_w[tlqe_pkg::LenW];
  assign len_o = root_w[tlqe_pkg::LenW];
  assign car_o = car_w[tlqe_pkg::LenW];

endmodule
`default_nettype wire

// ----- hw/rtl/tlqe_div.sv -----
// tlqe_div: pipelined restoring divider for both offset components
`default_nettype none
module tlqe_div (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      adv_i,
  input  wire logic                      vld_i,
  input  wire logic [tlqe_pkg::LenW-1:0] len_i,
  input  wire tlqe_pkg::carry_t          car_i,
  output logic                           vld_o,
  output logic [tlqe_pkg::QW-1:0]        qx_o,
  output logic [tlqe_pkg::QW-1:0]        qy_o,
  output tlqe_pkg::carry_t               car_o
);

  localparam int CmpW = tlqe_pkg::NumW + tlqe_pkg::LenW;

  logic                          vld_w [tlqe_pkg::QW+1];
  logic [tlqe_pkg::LenW-1:0]     len_w [tlqe_pkg::QW+1];
  logic [tlqe_pkg::NumW-1:0]     rx_w  [tlqe_pkg::QW+1];
  logic [tlqe_pkg::NumW-1:0]     ry_w  [tlqe_pkg::QW+1];
  logic [tlqe_pkg::QW-1:0]       qx_w  [tlqe_pkg::QW+1];
  logic [tlqe_pkg::QW-1:0]       qy_w  [tlqe_pkg::QW+1];
  tlqe_pkg::carry_t              car_w [tlqe_pkg::QW+1];

  assign vld_w[0] = vld_i;
  assign len_w[0] = len_i;
  assign rx_w[0]  = car_i.numx;
  assign ry_w[0]  = car_i.numy;
  assign qx_w[0]  = '0;
  assign qy_w[0]  = '0;
  assign car_w[0] = car_i;

  for (genvar k = 0; k < tlqe_pkg::QW; k++) begin : g_stage
    localparam int Bit = tlqe_pkg::QW - 1 - k;
    logic [CmpW-1:0] dvs_d;
    logic            gex_d, gey_d;

    assign dvs_d = CmpW'(len_w[k]) << Bit;
    assign gex_d = CmpW'(rx_w[k]) >= dvs_d;
    assign gey_d = CmpW'(ry_w[k]) >= dvs_d;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_w[k+1] <= 1'b0;
      end else if (adv_i) begin
        vld_w[k+1] <= vld_w[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        len_w[k+1] <= len_w[k];
        car_w[k+1] <= car_w[k];
        rx_w[k+1]  <= gex_d ? rx_w[k] - dvs_d[tlqe_pkg::NumW-1:0] : rx_w[k];
        ry_w[k+1]  <= gey_d ? ry_w[k] - dvs_d[tlqe_pkg::NumW-1:0] : ry_w[k];
        qx_w[k+1]  <= gex_d ? (qx_w[k] | (tlqe_pkg::QW'(1) << Bit)) : qx_w[k];
        qy_w[k+1]  <= gey_d ? (qy_w[k] | (tlqe_pkg::QW'(1) << Bit)) : qy_w[k];
      end
    end
  end

  assign vld_o = vld_w[tlqe_pkg::QW];
  assign qx_o  = qx_w[tlqe_pkg::QW];
  assign qy_o  = qy_w[tlqe_pkg::QW];
  assign car_o = car_w[tlqe_pkg::QW];

endmodule
`default_nettype wire

// ----- hw/rtl/tlqe_emit.sv -----
// tlqe_emit: corner sums with saturation and the six vertex beat sequencer
`default_nettype none
module tlqe_emit (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          vld_i,
  input  wire logic [tlqe_pkg::QW-1:0]       qx_i,
  input  wire logic [tlqe_pkg::QW-1:0]       qy_i,
  input  wire tlqe_pkg::carry_t              car_i,
  output logic                               adv_o,
  output logic                               vert_valid_o,
  output logic [tlqe_pkg::CoordBits-1:0]     vert_x_o,
  output logic [tlqe_pkg::CoordBits-1:0]     vert_y_o,
  output logic [tlqe_pkg::ColorBits-1:0]     vert_rgba_o,
  output logic                               last_vertex_o
);

  localparam int ExtC = tlqe_pkg::SumW - tlqe_pkg::CoordBits;
  localparam int ExtH = tlqe_pkg::SumW - tlqe_pkg::HW;

  logic [tlqe_pkg::HW-1:0]        hx_d, hy_d;
  logic [tlqe_pkg::SumW-1:0]      hxe_d, hye_d;
  logic [tlqe_pkg::SumW-1:0]      x1e_d, y1e_d, x2e_d, y2e_d;
  logic                           act_q;
  logic [tlqe_pkg::CntW-1:0]      cnt_q;
  logic [tlqe_pkg::CoordBits-1:0] apx_q, apy_q, amx_q, amy_q;
  logic [tlqe_pkg::CoordBits-1:0] bpx_q, bpy_q, bmx_q, bmy_q;
  logic [tlqe_pkg::ColorBits-1:0] rgba_q;

  assign adv_o = !act_q || (cnt_q == tlqe_pkg::LastIdx);

  assign hx_d  = car_i.negx ? tlqe_pkg::HW'(-{1'b0, qx_i}) : {1'b0, qx_i};
  assign hy_d  = car_i.negy ? tlqe_pkg::HW'(-{1'b0, qy_i}) : {1'b0, qy_i};
  assign hxe_d = {{ExtH{hx_d[tlqe_pkg::HW-1]}}, hx_d};
  assign hye_d = {{ExtH{hy_d[tlqe_pkg::HW-1]}}, hy_d};
  assign x1e_d = {{ExtC{car_i.seg.x1[tlqe_pkg::CoordBits-1]}}, car_i.seg.x1};
  assign y1e_d = {{ExtC{car_i.seg.y1[tlqe_pkg::CoordBits-1]}}, car_i.seg.y1};
  assign x2e_d = {{ExtC{car_i.seg.x2[tlqe_pkg::CoordBits-1]}}, car_i.seg.x2};
  assign y2e_d = {{ExtC{car_i.seg.y2[tlqe_pkg::CoordBits-1]}}, car_i.seg.y2};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      act_q <= 1'b0;
      cnt_q <= '0;
    end else if (adv_o) begin
      act_q <= vld_i && !car_i.zero;
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_q + tlqe_pkg::CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      apx_q  <= tlqe_pkg::sat_coord(x1e_d + hxe_d);
      apy_q  <= tlqe_pkg::sat_coord(y1e_d + hye_d);
      amx_q  <= tlqe_pkg::sat_coord(x1e_d - hxe_d);
      amy_q  <= tlqe_pkg::sat_coord(y1e_d - hye_d);
      bpx_q  <= tlqe_pkg::sat_coord(x2e_d + hxe_d);
      bpy_q  <= tlqe_pkg::sat_coord(y2e_d + hye_d);
      bmx_q  <= tlqe_pkg::sat_coord(x2e_d - hxe_d);
      bmy_q  <= tlqe_pkg::sat_coord(y2e_d - hye_d);
      rgba_q <= car_i.seg.rgba;
    end
  end

  always_comb begin
    case (cnt_q)
      3'd0: begin
        vert_x_o = apx_q;
        vert_y_o = apy_q;
      end
      3'd1, 3'd4: begin
        vert_x_o = amx_q;
        vert_y_o = amy_q;
      end
      3'd2, 3'd3: begin
        vert_x_o = bpx_q;
        vert_y_o = bpy_q;
      end
      default: begin
        vert_x_o = bmx_q;
        vert_y_o = bmy_q;
      end
    endcase
  end

  assign vert_valid_o  = act_q;
  assign vert_rgba_o   = rgba_q;
  assign last_vertex_o = act_q && (cnt_q == tlqe_pkg::LastIdx);

endmodule
`default_nettype wire

// ----- hw/rtl/thick_line_quad_expander_top.sv -----
// thick_line_quad_expander_top: segment to six vertex thick line quad expander
// once a segment is taken into an empty pipeline, its first vertex beat follows the front,
// square root, divider and sequencer registers, then one beat per cycle; each earlier
// segment ahead adds its vertex beats; a new segment waits for the last vertex of the one before
// a zero-length segment takes one pipeline slot and gives no beat
// busy is high while the sequencer still has vertices of an earlier segment to send
// reset clears all pipeline valid bits and the sequencer; no beat leaves until a segment is taken
`default_nettype none
module thick_line_quad_expander_top (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic signed [tlqe_pkg::CoordBits-1:0] start_x_i,
  input  wire logic signed [tlqe_pkg::CoordBits-1:0] start_y_i,
  input  wire logic signed [tlqe_pkg::CoordBits-1:0] end_x_i,
  input  wire logic signed [tlqe_pkg::CoordBits-1:0] end_y_i,
  input  wire logic [tlqe_pkg::WidthBits-1:0]        width_q4_i,
  input  wire logic [tlqe_pkg::ColorBits-1:0]        rgba_i,
  output logic                                      vert_valid_o,
  output logic signed [tlqe_pkg::CoordBits-1:0]     vert_x_o,
  output logic signed [tlqe_pkg::CoordBits-1:0]     vert_y_o,
  output logic [tlqe_pkg::ColorBits-1:0]            vert_rgba_o,
  output logic                                      last_vertex_o
);

  logic                          adv;
  tlqe_pkg::seg_t                seg_in;
  logic                          f_vld, s_vld, d_vld;
  logic [tlqe_pkg::RadW-1:0]     f_rad;
  tlqe_pkg::carry_t              f_car, s_car, d_car;
  logic [tlqe_pkg::LenW-1:0]     s_len;
  logic [tlqe_pkg::QW-1:0]       d_qx, d_qy;
  logic [tlqe_pkg::CoordBits-1:0] vx, vy;

  assign busy        = !adv;
  assign seg_in.x1   = start_x_i;
  assign seg_in.y1   = start_y_i;
  assign seg_in.x2   = end_x_i;
  assign seg_in.y2   = end_y_i;
  assign seg_in.rgba = rgba_i;

  tlqe_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .vld_i   (start),
    .seg_i   (seg_in),
    .width_i (width_q4_i),
    .vld_o   (f_vld),
    .rad_o   (f_rad),
    .car_o   (f_car)
  );

  tlqe_sqrt u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (f_vld),
    .rad_i  (f_rad),
    .car_i  (f_car),
    .vld_o  (s_vld),
    .len_o  (s_len),
    .car_o  (s_car)
  );

  tlqe_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .vld_i  (s_vld),
    .len_i  (s_len),
    .car_i  (s_car),
    .vld_o  (d_vld),
    .qx_o   (d_qx),
    .qy_o   (d_qy),
    .car_o  (d_car)
  );

  tlqe_emit u_emit (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .vld_i         (d_vld),
    .qx_i          (d_qx),
    .qy_i          (d_qy),
    .car_i         (d_car),
    .adv_o         (adv),
    .vert_valid_o  (vert_valid_o),
    .vert_x_o      (vx),
    .vert_y_o      (vy),
    .vert_rgba_o   (vert_rgba_o),
    .last_vertex_o (last_vertex_o)
  );

  assign vert_x_o = vx;
  assign vert_y_o = vy;

  a_last_after_five: assert property (@(posedge clk_i) disable iff (!rst_ni)
    last_vertex_o |-> $past(vert_valid_o, 5))
    else $error("last vertex without five earlier beats");

  a_quad_continues: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_valid_o && !last_vertex_o |=> vert_valid_o && $stable(vert_rgba_o))
    else $error("quad beats broken or color changed");

  a_free_only_at_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vert_valid_o && !busy |-> last_vertex_o)
    else $error("ready while vertices remain");

endmodule
`default_nettype wire
